// ----- rtl/pbld_pkg.sv -----
// Shared constants, types and helper function of the push-button light dimmer.
package pbld_pkg;

   localparam int TIME_WIDTH     = 24;
   localparam int DUTY_MAX_BOUND = 255;

   localparam int REQ_W   = 3;
   localparam int SCAN_W  = 10;
   localparam int DUTY_W  = 8;
   localparam int BOUND_W = 16;
   localparam int OFF_W   = 24;
   localparam int LONG_W  = 16;
   localparam int SLOT_W  = 16;
   localparam int STEP_W  = 8;
   localparam int RAMP_W  = 10;
   localparam int RING_W  = 12;
   localparam int SLOTS_W = 16;
   localparam int CMP_W   = 33;

   localparam logic [TIME_WIDTH-1:0] TIME_MAX      = '1;
   localparam logic [RING_W-1:0]     RING_TIME_MAX = '1;

   localparam int BLINK_HALF_MS = 350;
   localparam int BLINK_HIGH    = 85;
   localparam int BLINK_LOW     = 15;
   localparam int RING_LEN_MS   = 3000;
   localparam int BLINK_SLOTS   = ((1 << RING_W) - 1) / BLINK_HALF_MS;

   localparam int DIV_STEPS = (TIME_WIDTH + 1) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int REM_W     = SLOT_W + 1;

   localparam int PADDR_W = 5;
   localparam int PDATA_W = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_CAP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_TIMEOUT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_STEP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP        = 3'd5;

   localparam logic [DUTY_W-1:0] RST_LEVEL_CAP   = 8'd100;
   localparam logic [OFF_W-1:0]  RST_OFF_TIMEOUT = 24'd0;
   localparam logic [LONG_W-1:0] RST_LONG_PRESS  = 16'd1000;
   localparam logic [SLOT_W-1:0] RST_SLOT        = 16'd200;
   localparam logic [STEP_W-1:0] RST_FADE_STEP   = 8'd10;
   localparam logic [RAMP_W-1:0] RST_RAMP        = 10'd25;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK     = 3'd0,
      REQ_SET_DUTY = 3'd1,
      REQ_RING     = 3'd2,
      REQ_ON       = 3'd3,
      REQ_OFF      = 3'd4
   } req_kind_type;

   typedef struct packed {
      logic [DUTY_W-1:0] level_cap;
      logic [OFF_W-1:0]  off_timeout_ms;
      logic [LONG_W-1:0] long_press_ms;
      logic [SLOT_W-1:0] slot_ms;
      logic [STEP_W-1:0] fade_step;
      logic [RAMP_W-1:0] ramp_ms;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic div_init;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
   } status_type;

   // The blink is in its low half when the ring time has crossed an odd number
   // of half periods.
   function automatic logic blink_is_low(input logic [RING_W-1:0] ring_ms);
      logic parity;
      parity = 1'b0;
      for (int k = 1; k <= BLINK_SLOTS; k++) begin
         if (ring_ms >= RING_W'(k * BLINK_HALF_MS)) begin
            parity = ~parity;
         end
      end
      return parity;
   endfunction

endpackage

// ----- rtl/pbld_csr.sv -----
// Configuration register file of the dimmer behind an APB-style port.
module pbld_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pbld_pkg::PADDR_W-1:0]  paddr,
   input  logic [pbld_pkg::PDATA_W-1:0]  pwdata,
   output logic [pbld_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output pbld_pkg::cfg_type             cfg
);

   pbld_pkg::cfg_type                    cfg_ff;
   pbld_pkg::cfg_type                    cfg_in;
   logic [pbld_pkg::CSR_IDX_W-1:0]       index;
   logic                                 write_en;

   assign index    = paddr[pbld_pkg::PADDR_W-1:2];
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            pbld_pkg::CSR_LEVEL_CAP:   cfg_in.level_cap      = pwdata[pbld_pkg::DUTY_W-1:0];
            pbld_pkg::CSR_OFF_TIMEOUT: cfg_in.off_timeout_ms = pwdata[pbld_pkg::OFF_W-1:0];
            pbld_pkg::CSR_LONG_PRESS:  cfg_in.long_press_ms  = pwdata[pbld_pkg::LONG_W-1:0];
            pbld_pkg::CSR_SLOT:        cfg_in.slot_ms        = pwdata[pbld_pkg::SLOT_W-1:0];
            pbld_pkg::CSR_FADE_STEP:   cfg_in.fade_step      = pwdata[pbld_pkg::STEP_W-1:0];
            pbld_pkg::CSR_RAMP:        cfg_in.ramp_ms        = pwdata[pbld_pkg::RAMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         pbld_pkg::CSR_LEVEL_CAP:   prdata = pbld_pkg::PDATA_W'(cfg_ff.level_cap);
         pbld_pkg::CSR_OFF_TIMEOUT: prdata = pbld_pkg::PDATA_W'(cfg_ff.off_timeout_ms);
         pbld_pkg::CSR_LONG_PRESS:  prdata = pbld_pkg::PDATA_W'(cfg_ff.long_press_ms);
         pbld_pkg::CSR_SLOT:        prdata = pbld_pkg::PDATA_W'(cfg_ff.slot_ms);
         pbld_pkg::CSR_FADE_STEP:   prdata = pbld_pkg::PDATA_W'(cfg_ff.fade_step);
         pbld_pkg::CSR_RAMP:        prdata = pbld_pkg::PDATA_W'(cfg_ff.ramp_ms);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_cap      <= pbld_pkg::RST_LEVEL_CAP;
         cfg_ff.off_timeout_ms <= pbld_pkg::RST_OFF_TIMEOUT;
         cfg_ff.long_press_ms  <= pbld_pkg::RST_LONG_PRESS;
         cfg_ff.slot_ms        <= pbld_pkg::RST_SLOT;
         cfg_ff.fade_step      <= pbld_pkg::RST_FADE_STEP;
         cfg_ff.ramp_ms        <= pbld_pkg::RST_RAMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/pbld_datapath.sv -----
// Datapath of the dimmer: input capture, slot divider, state update and result register.
module pbld_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  pbld_pkg::cfg_type                  cfg,
   input  pbld_pkg::cmd_type                  cmd,
   output pbld_pkg::status_type               status,
   input  logic [pbld_pkg::REQ_W-1:0]         req_type,
   input  logic [pbld_pkg::SCAN_W-1:0]        req_scan_ms,
   input  logic                               req_switch_level,
   input  logic                               req_bell_level,
   input  logic [pbld_pkg::DUTY_W-1:0]        req_remote_duty,
   output logic [pbld_pkg::DUTY_W-1:0]        rsp_duty_out,
   output logic                               rsp_lamp_on,
   output logic                               rsp_ringing_active,
   output logic                               rsp_publish_flag
);

   localparam int TW = pbld_pkg::TIME_WIDTH;
   localparam int DW = pbld_pkg::DUTY_W;
   localparam int RW = pbld_pkg::RAMP_W;
   localparam int GW = pbld_pkg::RING_W;
   localparam int QW = pbld_pkg::DIV_W;
   localparam int MW = pbld_pkg::REM_W;
   localparam int CW = pbld_pkg::CMP_W;

   // Captured transaction.
   logic [pbld_pkg::REQ_W-1:0]  req_type_ff;
   logic [pbld_pkg::SCAN_W-1:0] scan_ff;
   logic                        switch_ff;
   logic                        bell_ff;
   logic [DW-1:0]               remote_duty_ff;

   // Dimmer state.
   logic [TW-1:0]                  press_time_ff, press_time_in;
   logic [GW-1:0]                  ring_time_ff, ring_time_in;
   logic [TW-1:0]                  on_time_ff, on_time_in;
   logic [pbld_pkg::SLOTS_W-1:0]   fade_slots_ff, fade_slots_in;
   logic                           fade_upward_ff, fade_upward_in;
   logic                           ramping_up_ff, ramping_up_in;
   logic                           ramping_down_ff, ramping_down_in;
   logic [RW-1:0]                  ramp_time_ff, ramp_time_in;
   logic [DW-1:0]                  duty_level_ff, duty_level_in;
   logic [DW-1:0]                  saved_duty_ff, saved_duty_in;
   logic                           ring_latched_ff, ring_latched_in;
   logic                           publish_in;

   // Result register.
   logic [DW-1:0] rsp_duty_ff;
   logic          rsp_lamp_ff;
   logic          rsp_ringing_ff;
   logic          rsp_publish_ff;

   // Slot divider.
   logic [QW-1:0] div_num_ff, div_num_in;
   logic [MW-2:0] div_rem_ff, div_rem_in;
   logic [QW-1:0] div_num_init;
   logic [MW-1:0] divisor;

   logic [DW-1:0] lim;
   logic [TW:0]   press_sum;
   logic [TW-1:0] press_next;
   logic          press_over;

   assign lim = (pbld_pkg::BOUND_W'(cfg.level_cap) > pbld_pkg::BOUND_W'(pbld_pkg::DUTY_MAX_BOUND))
              ? DW'(pbld_pkg::DUTY_MAX_BOUND) : cfg.level_cap;

   assign press_sum  = {1'b0, press_time_ff} + (TW + 1)'(scan_ff);
   assign press_next = !switch_ff ? '0 : (press_sum[TW] ? pbld_pkg::TIME_MAX : press_sum[TW-1:0]);
   assign press_over = CW'(press_next) > CW'(cfg.long_press_ms);

   assign status.is_tick = (req_type_ff == pbld_pkg::REQ_TICK);

   assign divisor      = (cfg.slot_ms == '0) ? MW'(1) : MW'(cfg.slot_ms);
   assign div_num_init = press_over ? QW'(press_next - TW'(cfg.long_press_ms)) : '0;

   // Two restoring quotient bits per cycle.
   always_comb begin
      logic [MW-1:0] r1;
      logic [MW-1:0] r2;
      logic [QW-1:0] n1;
      logic          ge1;
      logic          ge2;
      r1  = {div_rem_ff, div_num_ff[QW-1]};
      ge1 = r1 >= divisor;
      if (ge1) begin
         r1 = r1 - divisor;
      end
      n1  = {div_num_ff[QW-2:0], ge1};
      r2  = {r1[MW-2:0], n1[QW-1]};
      ge2 = r2 >= divisor;
      if (ge2) begin
         r2 = r2 - divisor;
      end
      div_num_in = {n1[QW-2:0], ge2};
      div_rem_in = r2[MW-2:0];
   end

   always_comb begin
      logic          on;
      logic          lp;
      logic          sp;
      logic          rup;
      logic          rdown;
      logic          ringing;
      logic          rl;
      logic          upward;
      logic [GW:0]   ring_sum;
      logic [TW:0]   on_sum;
      logic [TW-1:0] on_t;
      logic [RW:0]   t;
      logic [RW-1:0] rm;
      logic [DW:0]   up_sum;
      logic [DW-1:0] duty;
      logic [pbld_pkg::SLOTS_W-1:0] slots;

      press_time_in   = press_time_ff;
      ring_time_in    = ring_time_ff;
      on_time_in      = on_time_ff;
      fade_slots_in   = fade_slots_ff;
      fade_upward_in  = fade_upward_ff;
      ramping_up_in   = ramping_up_ff;
      ramping_down_in = ramping_down_ff;
      ramp_time_in    = ramp_time_ff;
      duty_level_in   = duty_level_ff;
      saved_duty_in   = saved_duty_ff;
      ring_latched_in = ring_latched_ff;
      publish_in      = 1'b0;

      on       = duty_level_ff != '0;
      lp       = CW'(press_time_ff) > CW'(cfg.long_press_ms);
      sp       = (press_time_ff != '0) && !switch_ff && !lp;
      ring_sum = {1'b0, ring_time_ff} + (GW + 1)'(scan_ff);
      on_sum   = {1'b0, on_time_ff} + (TW + 1)'(scan_ff);
      on_t     = on_time_ff;
      rup      = ramping_up_ff;
      rdown    = ramping_down_ff;
      rm       = (cfg.ramp_ms == '0) ? RW'(1) : cfg.ramp_ms;
      t        = {1'b0, ramp_time_ff} + (RW + 1)'(scan_ff);
      duty     = duty_level_ff;
      slots    = fade_slots_ff;
      upward   = fade_upward_ff;
      up_sum   = '0;
      rl       = ring_latched_ff;
      ringing  = 1'b0;

      if (req_type_ff != pbld_pkg::REQ_TICK) begin
         case (req_type_ff)
            pbld_pkg::REQ_SET_DUTY: begin
               duty_level_in = remote_duty_ff;
               on_time_in    = '0;
            end
            pbld_pkg::REQ_RING: begin
               ring_latched_in = 1'b1;
            end
            pbld_pkg::REQ_ON: begin
               ramping_up_in   = 1'b1;
               ramping_down_in = 1'b0;
            end
            pbld_pkg::REQ_OFF: begin
               if (on) begin
                  ramping_down_in = 1'b1;
               end
               ramping_up_in = 1'b0;
            end
            default: ;
         endcase
      end else begin
         press_time_in = press_next;
         ring_time_in  = !ring_latched_ff ? '0
                       : (ring_sum[GW] ? pbld_pkg::RING_TIME_MAX : ring_sum[GW-1:0]);
         if (cfg.off_timeout_ms != '0) begin
            on_t = on_sum[TW] ? pbld_pkg::TIME_MAX : on_sum[TW-1:0];
         end
         if (!on) begin
            on_t = '0;
         end
         on_time_in = on_t;
         if (CW'(on_t) > CW'(cfg.off_timeout_ms) && !rup) begin
            rdown = 1'b1;
         end

         if (sp && (rup || rdown)) begin
            rup   = 1'b0;
            rdown = 1'b0;
            sp    = 1'b0;
         end
         if (sp) begin
            if (on) begin
               rdown = 1'b1;
            end else begin
               rup = 1'b1;
            end
         end

         if (rup || rdown) begin
            if (t >= {1'b0, rm}) begin
               t = t - {1'b0, rm};
               if (t >= {1'b0, rm}) begin
                  t = {1'b0, rm - RW'(1)};
               end
               if (rup) begin
                  if (duty < lim) begin
                     duty = duty + DW'(1);
                  end
                  if (duty >= lim) begin
                     rup = 1'b0;
                  end
               end else begin
                  if (duty != '0) begin
                     duty = duty - DW'(1);
                  end
                  if (duty == '0) begin
                     rdown = 1'b0;
                  end
               end
            end
            ramp_time_in = t[RW-1:0];
         end else begin
            ramp_time_in = '0;
         end

         if (!switch_ff) begin
            slots  = '0;
            upward = 1'b0;
            lp     = 1'b0;
         end
         if (lp && (CW'(slots) < CW'(div_num_ff))) begin
            if (slots != '1) begin
               slots = slots + pbld_pkg::SLOTS_W'(1);
            end
            if (upward) begin
               up_sum = {1'b0, duty} + (DW + 1)'(cfg.fade_step);
               if (up_sum >= {1'b0, lim}) begin
                  duty   = lim;
                  upward = 1'b0;
               end else begin
                  duty = up_sum[DW-1:0];
               end
            end else if (duty <= cfg.fade_step) begin
               duty   = cfg.fade_step;
               upward = 1'b1;
            end else begin
               duty = duty - cfg.fade_step;
            end
         end

         if (bell_ff || rl) begin
            duty    = pbld_pkg::blink_is_low(ring_time_in) ? DW'(pbld_pkg::BLINK_LOW)
                                                          : DW'(pbld_pkg::BLINK_HIGH);
            ringing = 1'b1;
            rl      = 1'b1;
            if (ring_time_in > GW'(pbld_pkg::RING_LEN_MS)) begin
               rl = 1'b0;
            end
         end
         if (ringing && !rl) begin
            duty = saved_duty_ff;
         end
         if (duty >= lim) begin
            duty = lim;
         end
         if (duty != saved_duty_ff && !rup && !rdown && !rl) begin
            saved_duty_in = duty;
            publish_in    = 1'b1;
         end

         fade_slots_in   = slots;
         fade_upward_in  = upward;
         ramping_up_in   = rup;
         ramping_down_in = rdown;
         duty_level_in   = duty;
         ring_latched_in = rl;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff    <= req_type;
         scan_ff        <= req_scan_ms;
         switch_ff      <= req_switch_level;
         bell_ff        <= req_bell_level;
         remote_duty_ff <= req_remote_duty;
      end
      if (cmd.div_init) begin
         div_num_ff <= div_num_init;
         div_rem_ff <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
      end
      if (cmd.commit) begin
         rsp_duty_ff    <= duty_level_in;
         rsp_lamp_ff    <= duty_level_in != '0;
         rsp_ringing_ff <= ring_latched_in;
         rsp_publish_ff <= publish_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_time_ff   <= '0;
         ring_time_ff    <= '0;
         on_time_ff      <= '0;
         fade_slots_ff   <= '0;
         fade_upward_ff  <= 1'b0;
         ramping_up_ff   <= 1'b0;
         ramping_down_ff <= 1'b0;
         ramp_time_ff    <= '0;
         duty_level_ff   <= '0;
         saved_duty_ff   <= '0;
         ring_latched_ff <= 1'b0;
      end else if (cmd.commit) begin
         press_time_ff   <= press_time_in;
         ring_time_ff    <= ring_time_in;
         on_time_ff      <= on_time_in;
         fade_slots_ff   <= fade_slots_in;
         fade_upward_ff  <= fade_upward_in;
         ramping_up_ff   <= ramping_up_in;
         ramping_down_ff <= ramping_down_in;
         ramp_time_ff    <= ramp_time_in;
         duty_level_ff   <= duty_level_in;
         saved_duty_ff   <= saved_duty_in;
         ring_latched_ff <= ring_latched_in;
      end
   end

   assign rsp_duty_out       = rsp_duty_ff;
   assign rsp_lamp_on        = rsp_lamp_ff;
   assign rsp_ringing_active = rsp_ringing_ff;
   assign rsp_publish_flag   = rsp_publish_ff;

endmodule

// ----- rtl/pbld_ctrl.sv -----
// Controller state machine of the dimmer: handshakes, divider sequencing and commit.
module pbld_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pbld_pkg::status_type  status,
   output pbld_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVINIT,
      S_DIV,
      S_COMMIT
   } state_type;

   localparam logic [pbld_pkg::DIV_CNT_W-1:0] LAST_STEP =
      pbld_pkg::DIV_CNT_W'(pbld_pkg::DIV_STEPS - 1);

   state_type                        state_ff, state_in;
   logic [pbld_pkg::DIV_CNT_W-1:0]   step_ff, step_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             out_blocked;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = out_blocked;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DIVINIT;
            end
         end
         S_DIVINIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = status.is_tick ? S_DIV : S_COMMIT;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_COMMIT;
            end else begin
               step_in = step_ff + pbld_pkg::DIV_CNT_W'(1);
            end
         end
         S_COMMIT: begin
            if (!out_blocked) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_commit_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("Result overwritten while the previous transaction was stalled.");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("Committed transaction did not raise rsp_valid.");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> step_ff <= LAST_STEP)
      else $error("Divider step count ran past the last step.");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_DIVINIT)
      else $error("Accepted transaction did not start processing.");

endmodule

// ----- rtl/push_button_light_dimmer_top.sv -----
// Top level of the push-button light dimmer.
// Each transaction yields exactly one result. A remote event (set duty, ring, on,
// off) passes through the capture, divider-init and commit states; a scan tick
// also runs the divider steps before its commit, because the long-press slot
// number is produced by a divider that retires two quotient bits per cycle. The
// block takes the next transaction in the cycle after a result is produced and none
// before the last one is committed. The next transaction is accepted while a finished
// result still waits on rsp_stall; it then holds in its commit state until the result
// register is free. Configuration registers sit at byte addresses 4*i; the user must
// write them only while the block is idle, which the block does not enforce.
module push_button_light_dimmer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [pbld_pkg::REQ_W-1:0]         req_type,
   input  logic [pbld_pkg::SCAN_W-1:0]        req_scan_ms,
   input  logic                               req_switch_level,
   input  logic                               req_bell_level,
   input  logic [pbld_pkg::DUTY_W-1:0]        req_remote_duty,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pbld_pkg::DUTY_W-1:0]        rsp_duty_out,
   output logic                               rsp_lamp_on,
   output logic                               rsp_ringing_active,
   output logic                               rsp_publish_flag,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pbld_pkg::PADDR_W-1:0]       paddr,
   input  logic [pbld_pkg::PDATA_W-1:0]       pwdata,
   output logic [pbld_pkg::PDATA_W-1:0]       prdata,
   output logic                               pready
);

   pbld_pkg::cfg_type    cfg;
   pbld_pkg::cmd_type    cmd;
   pbld_pkg::status_type status;

   pbld_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pbld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pbld_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .req_scan_ms        (req_scan_ms),
      .req_switch_level   (req_switch_level),
      .req_bell_level     (req_bell_level),
      .req_remote_duty    (req_remote_duty),
      .rsp_duty_out       (rsp_duty_out),
      .rsp_lamp_on        (rsp_lamp_on),
      .rsp_ringing_active (rsp_ringing_active),
      .rsp_publish_flag   (rsp_publish_flag)
   );

endmodule
